FILE: src/fdd_pkg.sv
// Shared constants and rule-table functions for the fuzzy differential drive controller.
// It depends on nothing else.
package fdd_pkg;

    localparam int MU_W   = 9;   // membership and rule strength width, 0..256
    localparam int DEN_W  = 12;  // strength sum width, at most nine times 256
    localparam int SUM_W  = 20;  // signed sum of strength times centre
    localparam int M_W    = 14;  // scaled membership numerator width
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_50 = 1310;  // floor(2^16 / 50)
    localparam int RECIP_45 = 1456;  // floor(2^16 / 45)
    localparam int N_RULES = 9;

    typedef logic [MU_W-1:0] mu_t;
    typedef logic [2:0][MU_W-1:0] mu_set_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    // Rule centres in whole percent, index is distance row times three plus angle column.
    function automatic logic signed [7:0] left_centre(input logic [3:0] idx);
        logic signed [7:0] c;
        case (idx)
            4'd0:    c = -8'sd50;
            4'd1:    c = 8'sd0;
            4'd2:    c = 8'sd50;
            4'd3:    c = 8'sd0;
            4'd4:    c = 8'sd50;
            4'd5:    c = 8'sd50;
            4'd6:    c = 8'sd50;
            4'd7:    c = 8'sd100;
            4'd8:    c = 8'sd100;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [7:0] right_centre(input logic [3:0] idx);
        logic signed [7:0] c;
        case (idx)
            4'd0:    c = 8'sd50;
            4'd1:    c = 8'sd0;
            4'd2:    c = -8'sd50;
            4'd3:    c = 8'sd50;
            4'd4:    c = 8'sd50;
            4'd5:    c = 8'sd0;
            4'd6:    c = 8'sd100;
            4'd7:    c = 8'sd100;
            4'd8:    c = 8'sd50;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

endpackage

FILE: src/fdd_member.sv
// Input clamping and triangular membership evaluation, three register stages.
// Depends on fdd_pkg.
module fdd_member #(
    parameter int FRAC_BITS = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    valid,
    input  logic [14:0]             distance,
    input  logic signed [14:0]      angle,
    output logic                    mu_valid,
    output fdd_pkg::mu_set_t        md,
    output fdd_pkg::mu_set_t        ma
);
    import fdd_pkg::*;

    localparam int signed U45  = 45 <<< FRAC_BITS;
    localparam int signed U50  = 50 <<< FRAC_BITS;
    localparam int signed U100 = 100 <<< FRAC_BITS;

    // Scales a numerator in input units to a Q0.8 numerator over the whole-unit divisor.
    function automatic logic [M_W-1:0] scale(input logic signed [31:0] n);
        logic [39:0] w;
        w = {n, 8'b0} >> FRAC_BITS;
        return w[M_W-1:0];
    endfunction

    logic signed [31:0] dx, ax;
    logic [2:0][M_W-1:0] md_m, ma_m;

    logic [2:0]          v_reg;
    logic [2:0][M_W-1:0] dm_reg, am_reg, dm2_reg, am2_reg;
    logic [2:0][MU_W-1:0] dq_reg, aq_reg;
    mu_set_t             md_reg, ma_reg;
    mu_set_t             md_next, ma_next;
    logic [2:0][MU_W-1:0] dq_next, aq_next;

    always_comb
    begin
        dx = {17'b0, distance};
        if (dx == 32'sd0)
            dx = 32'sd1;
        if (dx >= U100)
            dx = U100 - 32'sd1;
        ax = 32'(angle);
        if (ax <= -U45)
            ax = -U45 + 32'sd1;
        if (ax >= U45)
            ax = U45 - 32'sd1;

        md_m[0] = (dx < U50) ? scale(U50 - dx) : '0;
        md_m[1] = (dx <= U50) ? scale(dx) : scale(U100 - dx);
        md_m[2] = (dx > U50) ? scale(dx - U50) : '0;
        ma_m[0] = (ax < 0) ? scale(-ax) : '0;
        ma_m[1] = (ax <= 0) ? scale(ax + U45) : scale(U45 - ax);
        ma_m[2] = (ax > 0) ? scale(ax) : '0;
    end

    // Quotient estimate by reciprocal, at most one short of the true value.
    always_comb
    begin
        logic [M_W+11:0] pd, pa;
        for (int k = 0; k < 3; k++)
        begin
            pd = M_W'(dm_reg[k]) * 12'(RECIP_50);
            pa = M_W'(am_reg[k]) * 12'(RECIP_45);
            dq_next[k] = pd[RECIP_SHIFT +: MU_W];
            aq_next[k] = pa[RECIP_SHIFT +: MU_W];
        end
    end

    always_comb
    begin
        logic [M_W-1:0] rd, ra;
        for (int k = 0; k < 3; k++)
        begin
            rd = dm2_reg[k] - M_W'(dq_reg[k]) * M_W'(50);
            ra = am2_reg[k] - M_W'(aq_reg[k]) * M_W'(45);
            md_next[k] = (rd >= M_W'(50)) ? dq_reg[k] + 1'b1 : dq_reg[k];
            ma_next[k] = (ra >= M_W'(45)) ? aq_reg[k] + 1'b1 : aq_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[1:0], valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dm_reg  <= md_m;
            am_reg  <= ma_m;
            dm2_reg <= dm_reg;
            am2_reg <= am_reg;
            dq_reg  <= dq_next;
            aq_reg  <= aq_next;
            md_reg  <= md_next;
            ma_reg  <= ma_next;
        end
    end

    assign mu_valid = v_reg[2];
    assign md = md_reg;
    assign ma = ma_reg;

endmodule

FILE: src/fdd_rules.sv
// Min inference over the nine rules and the weighted centre sums, two register stages.
// Depends on fdd_pkg.
module fdd_rules (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    mu_valid,
    input  fdd_pkg::mu_set_t        md,
    input  fdd_pkg::mu_set_t        ma,
    output logic                    sum_valid,
    output fdd_pkg::sum_t           sum_left,
    output fdd_pkg::sum_t           sum_right,
    output logic [fdd_pkg::DEN_W-1:0] den
);
    import fdd_pkg::*;

    logic [1:0]                 v_reg;
    logic [N_RULES-1:0][MU_W-1:0] w_reg, w_next;
    sum_t                       sl_reg, sr_reg, sl_next, sr_next;
    logic [DEN_W-1:0]           den_reg, den_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                w_next[i*3+j] = (md[i] < ma[j]) ? md[i] : ma[j];
    end

    always_comb
    begin
        sl_next  = '0;
        sr_next  = '0;
        den_next = '0;
        for (int k = 0; k < N_RULES; k++)
        begin
            sl_next  = sl_next + SUM_W'($signed({1'b0, w_reg[k]}))
                                 * SUM_W'(left_centre(4'(k)));
            sr_next  = sr_next + SUM_W'($signed({1'b0, w_reg[k]}))
                                 * SUM_W'(right_centre(4'(k)));
            den_next = den_next + DEN_W'(w_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[0], mu_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg   <= w_next;
            sl_reg  <= sl_next;
            sr_reg  <= sr_next;
            den_reg <= den_next;
        end
    end

    assign sum_valid = v_reg[1];
    assign sum_left  = sl_reg;
    assign sum_right = sr_reg;
    assign den       = den_reg;

endmodule

FILE: src/fdd_divider.sv
// Pipelined restoring divider for both motor channels, one quotient bit per stage.
// Depends on fdd_pkg.
module fdd_divider #(
    parameter int FRAC_BITS = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    sum_valid,
    input  fdd_pkg::sum_t           sum_left,
    input  fdd_pkg::sum_t           sum_right,
    input  logic [fdd_pkg::DEN_W-1:0] den,
    output logic                    q_valid,
    output logic [FRAC_BITS+6:0]    q_left,
    output logic [FRAC_BITS+6:0]    q_right,
    output logic                    neg_left,
    output logic                    neg_right,
    output logic                    den_zero
);
    import fdd_pkg::*;

    localparam int QW = FRAC_BITS + 7;   // quotient magnitude below 128 units
    localparam int RW = FRAC_BITS + 19;  // remainder and shifted divisor width

    logic [QW:0]                v_reg;
    logic [QW:0][1:0][RW-1:0]   rem_reg;
    logic [QW:0][1:0][QW-1:0]   quo_reg;
    logic [QW:0][DEN_W-1:0]     den_reg;
    logic [QW:0][1:0]           neg_reg;

    logic [QW-1:0][1:0][RW-1:0] rem_next;
    logic [QW-1:0][1:0][QW-1:0] quo_next;

    logic [1:0][RW-1:0] rem_in;
    sum_t               mag_l, mag_r;

    always_comb
    begin
        mag_l = sum_left[SUM_W-1] ? -sum_left : sum_left;
        mag_r = sum_right[SUM_W-1] ? -sum_right : sum_right;
        rem_in[0] = RW'(mag_l) << FRAC_BITS;
        rem_in[1] = RW'(mag_r) << FRAC_BITS;
    end

    // Stage s decides quotient bit QW-1-s against the divisor shifted to that bit.
    always_comb
    begin
        logic [RW-1:0] dsh;
        for (int s = 0; s < QW; s++)
        begin
            dsh = RW'(den_reg[s]) << (QW - 1 - s);
            for (int c = 0; c < 2; c++)
            begin
                rem_next[s][c] = rem_reg[s][c];
                quo_next[s][c] = quo_reg[s][c];
                if (rem_reg[s][c] >= dsh)
                begin
                    rem_next[s][c]             = rem_reg[s][c] - dsh;
                    quo_next[s][c][QW - 1 - s] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[QW-1:0], sum_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem_in;
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            neg_reg[0] <= {sum_right[SUM_W-1], sum_left[SUM_W-1]};
            for (int s = 0; s < QW; s++)
            begin
                rem_reg[s+1] <= rem_next[s];
                quo_reg[s+1] <= quo_next[s];
                den_reg[s+1] <= den_reg[s];
                neg_reg[s+1] <= neg_reg[s];
            end
        end
    end

    assign q_valid   = v_reg[QW];
    assign q_left    = quo_reg[QW][0];
    assign q_right   = quo_reg[QW][1];
    assign neg_left  = neg_reg[QW][0];
    assign neg_right = neg_reg[QW][1];
    assign den_zero  = (den_reg[QW] == '0);

endmodule

FILE: src/fuzzy_differential_drive_controller_unit.sv
// Top level of the fuzzy differential drive controller: membership, rules, divider, output.
// Depends on fdd_pkg, fdd_member, fdd_rules and fdd_divider.
//
//  channel   signals                              direction  request
//  in        in_valid in_ready distance angle     into block one sensor sample
//  out       out_valid out_ready left_power       out of     one pair of motor powers
//            right_power
//
// A request passes FRAC_BITS + 14 register stages: three stages of membership
// evaluation, two of rule inference, one to enter the divider, one per quotient bit
// (FRAC_BITS + 7 of them) and the output register. The first of them loads at the
// accepting edge. A new request is accepted in every cycle while no result is refused;
// the divider is fully pipelined. Reset clears only the valid bits; data registers fill
// as requests flow. When a result waits and out_ready is low, every stage holds, so
// nothing is lost.
module fuzzy_differential_drive_controller_unit #(
    parameter int FRAC_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [14:0]        distance,
    input  logic signed [14:0] angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] left_power,
    output logic signed [15:0] right_power
);
    import fdd_pkg::*;

    localparam int QW = FRAC_BITS + 7;

    // One enable moves the whole pipeline; it holds only while a result is refused.
    logic en;

    logic               mu_valid;
    mu_set_t            md, ma;
    logic               sum_valid;
    sum_t               sum_left, sum_right;
    logic [DEN_W-1:0]   den;
    logic               q_valid, neg_left, neg_right, den_zero;
    logic [QW-1:0]      q_left, q_right;

    logic               out_valid_reg;
    logic signed [15:0] left_reg, right_reg, left_next, right_next;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    fdd_member #(.FRAC_BITS(FRAC_BITS)) u_member (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .valid    (in_valid),
        .distance (distance),
        .angle    (angle),
        .mu_valid (mu_valid),
        .md       (md),
        .ma       (ma)
    );

    fdd_rules u_rules (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .mu_valid  (mu_valid),
        .md        (md),
        .ma        (ma),
        .sum_valid (sum_valid),
        .sum_left  (sum_left),
        .sum_right (sum_right),
        .den       (den)
    );

    fdd_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .sum_valid (sum_valid),
        .sum_left  (sum_left),
        .sum_right (sum_right),
        .den       (den),
        .q_valid   (q_valid),
        .q_left    (q_left),
        .q_right   (q_right),
        .neg_left  (neg_left),
        .neg_right (neg_right),
        .den_zero  (den_zero)
    );

    // Saturates a quotient magnitude to 16 bits and restores its sign.
    function automatic logic signed [15:0] finish(input logic [QW-1:0] q, input logic neg);
        logic [31:0]  m;
        logic [15:0]  v;
        m = 32'(q);
        if (neg)
            v = (m > 32'd32768) ? 16'h8000 : 16'(-m);
        else
            v = (m > 32'd32767) ? 16'h7fff : 16'(m);
        return $signed(v);
    endfunction

    always_comb
    begin
        if (den_zero)
        begin
            left_next  = '0;
            right_next = '0;
        end
        else
        begin
            left_next  = finish(q_left, neg_left);
            right_next = finish(q_right, neg_right);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_power  = left_reg;
    assign right_power = right_reg;

    // The input side is open exactly when the output register can move.
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow the output stall");

    // Clamping keeps the strength sum away from zero for every valid request.
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> !den_zero)
        else $error("zero strength sum reached the output stage");

    // A refused result is still presented in the next cycle.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(left_power)))
        else $error("refused result was dropped");

endmodule
